/* hw/rtl/i2cm_pkg.sv */
// Package for the I2C master transaction engine.
// Holds the command codes, the bus phase type and the request and response beat structs.
// Depends on nothing.
`default_nettype none

package i2cm_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_BEGIN = 2'd2;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'd0,
		PH_START_HOLD = 5'd1,
		PH_START_LOW  = 5'd2,
		PH_ABIT_LOW   = 5'd3,
		PH_ABIT_HIGH  = 5'd4,
		PH_AACK_LOW   = 5'd5,
		PH_AACK_HIGH  = 5'd6,
		PH_DBIT_LOW   = 5'd7,
		PH_DBIT_HIGH  = 5'd8,
		PH_DACK_LOW   = 5'd9,
		PH_DACK_HIGH  = 5'd10,
		PH_STOP_LOW   = 5'd11,
		PH_STOP_HIGH  = 5'd12
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic       sda_in;
		logic       read_not_write;
		logic [6:0] device_address;
		logic [4:0] byte_count;
		logic [3:0] buffer_index;
		logic [7:0] write_byte;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_driving;
		logic       busy_res;
		logic       read_valid;
		logic [3:0] read_index;
		logic [7:0] read_byte;
		logic       ack_valid;
		logic       ack_bit;
		logic       done_res;
		logic       rejected;
	} rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/i2c_master_transaction_engine_top.sv */
// A result beat appears in the output register in the cycle after its request is taken.
// Throughput: one request beat per clock; the output register takes a new beat while the
// previous one is read out, so only a stalled response side holds requests back.
// The write-buffer byte for each acknowledge is prefetched from the RAM, whose read data is registered.
// Reset clears the sequencer to idle with SCL and SDA released high and the output empty;
// the write buffer is not cleared.
// Top level: sequencer, write-buffer RAM and output register. Depends on i2cm_pkg.
`default_nettype none

module i2c_master_transaction_engine_top import i2cm_pkg::*; #(
	parameter int BUF_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp_data
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic          fire;
	rsp_t          seq_rsp;
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [7:0]    ram_wr_data;
	logic [AW-1:0] ram_rd_addr;
	logic [7:0]    ram_rd_data;

	assign req_ready = !rsp_valid || rsp_ready;
	assign fire      = req_valid && req_ready;

	i2cm_seq #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.req         (req_data),
		.rsp         (seq_rsp),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	i2cm_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_wbuf (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (fire) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_data <= seq_rsp;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/i2cm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// Depends on nothing.
`default_nettype none

module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* hw/rtl/i2cm_seq.sv */
// Bus sequencer: phase machine, bit and byte counters, shift register and line levels.
// Prefetches the next write-buffer byte from the RAM and bypasses a load of the last cycle.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq import i2cm_pkg::*; #(
	parameter int BUF_DEPTH = 16,
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire req_t          req,
	output rsp_t               rsp,
	output logic               ram_wr_en,
	output logic [AW-1:0]      ram_wr_addr,
	output logic [7:0]         ram_wr_data,
	output logic [AW-1:0]      ram_rd_addr,
	input  wire logic [7:0]    ram_rd_data
);

	localparam int IW = (AW > 5) ? AW : 5;
	localparam logic [8:0] DEPTH_W = 9'(BUF_DEPTH);

	phase_t     phase_q, phase_d;
	logic [3:0] bitc_q, bitc_d;
	logic [4:0] bytec_q, bytec_d;
	logic [7:0] shift_q, shift_d;
	logic [6:0] tgt_q, tgt_d;
	logic       rmode_q, rmode_d;
	logic [4:0] len_q, len_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       drv_q, drv_d;
	logic       byp_hit_q;
	logic [7:0] byp_data_q;

	logic [7:0] buf_byte;
	logic [4:0] bc_inc;
	logic [3:0] bitc_dec;
	logic       more_aack, more_dack, last_read;
	logic [IW-1:0] wr_idx, rd_idx;
	logic       in_data_phase;

	logic       rv, av, ab, dn, rj;
	logic [3:0] ri;
	logic [7:0] rb;
	logic       nb_take;
	logic       nb_more;

	assign bc_inc    = bytec_q + 5'd1;
	assign bitc_dec  = bitc_q - 4'd1;
	assign more_aack = (len_q != 5'd0);
	assign more_dack = (bc_inc < len_q);
	assign last_read = ({1'b0, bytec_q} + 6'd1) >= {1'b0, len_q};
	assign buf_byte  = byp_hit_q ? byp_data_q : ram_rd_data;

	// Buffer write port for loads; slots beyond the depth are dropped
	assign wr_idx      = IW'(req.buffer_index);
	assign ram_wr_en   = fire && (req.command == CMD_LOAD)
	                     && ({5'd0, req.buffer_index} < DEPTH_W);
	assign ram_wr_addr = wr_idx[AW-1:0];
	assign ram_wr_data = req.write_byte;

	// Prefetch the byte the next acknowledge will send: slot 0 before data, else count + 1
	assign in_data_phase = (phase_q == PH_DBIT_LOW) || (phase_q == PH_DBIT_HIGH)
	                       || (phase_q == PH_DACK_LOW) || (phase_q == PH_DACK_HIGH);
	assign rd_idx      = in_data_phase ? (IW'(bytec_q) + IW'(1)) : '0;
	assign ram_rd_addr = rd_idx[AW-1:0];

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (req.command == CMD_BEGIN) begin
			if (phase_q == PH_IDLE) begin
				phase_d = PH_START_HOLD;
			end
		end else if (req.command == CMD_TICK) begin
			case (phase_q)
				PH_START_HOLD: phase_d = PH_START_LOW;
				PH_START_LOW:  phase_d = PH_ABIT_LOW;
				PH_ABIT_LOW:   phase_d = PH_ABIT_HIGH;
				PH_AACK_LOW:   phase_d = PH_AACK_HIGH;
				PH_DBIT_LOW:   phase_d = PH_DBIT_HIGH;
				PH_DACK_LOW:   phase_d = PH_DACK_HIGH;
				PH_ABIT_HIGH:  phase_d = (bitc_q != 4'd0) ? PH_ABIT_LOW : PH_AACK_LOW;
				PH_DBIT_HIGH:  phase_d = (bitc_q != 4'd0) ? PH_DBIT_LOW : PH_DACK_LOW;
				PH_AACK_HIGH:  phase_d = more_aack ? PH_DBIT_LOW : PH_STOP_LOW;
				PH_DACK_HIGH:  phase_d = more_dack ? PH_DBIT_LOW : PH_STOP_LOW;
				PH_STOP_LOW:   phase_d = PH_STOP_HIGH;
				PH_STOP_HIGH:  phase_d = PH_IDLE;
				default:       phase_d = phase_q;
			endcase
		end
	end

	// Datapath and result fields
	always_comb begin
		bitc_d  = bitc_q;
		bytec_d = bytec_q;
		shift_d = shift_q;
		tgt_d   = tgt_q;
		rmode_d = rmode_q;
		len_d   = len_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		drv_d   = drv_q;
		rv      = 1'b0;
		ri      = 4'd0;
		rb      = 8'd0;
		av      = 1'b0;
		ab      = 1'b0;
		dn      = 1'b0;
		rj      = 1'b0;
		nb_take = 1'b0;
		nb_more = 1'b0;
		if (req.command == CMD_BEGIN) begin
			if (phase_q != PH_IDLE) begin
				rj = 1'b1;
			end else begin
				tgt_d   = req.device_address;
				rmode_d = req.read_not_write;
				len_d   = ({4'd0, req.byte_count} > DEPTH_W) ? 5'(BUF_DEPTH) : req.byte_count;
				bitc_d  = 4'd0;
				bytec_d = 5'd0;
				shift_d = 8'd0;
				scl_d   = 1'b1;
				sda_d   = 1'b1;
				drv_d   = 1'b1;
			end
		end else if (req.command == CMD_TICK) begin
			case (phase_q)
				PH_START_HOLD: begin
					sda_d = 1'b0;
				end
				PH_START_LOW: begin
					shift_d = {tgt_q, rmode_q};
					bitc_d  = 4'd7;
					scl_d   = 1'b0;
					drv_d   = 1'b1;
					sda_d   = tgt_q[6];
				end
				PH_ABIT_LOW, PH_AACK_LOW, PH_DBIT_LOW, PH_DACK_LOW: begin
					scl_d = 1'b1;
				end
				PH_ABIT_HIGH: begin
					scl_d = 1'b0;
					if (bitc_q != 4'd0) begin
						bitc_d = bitc_dec;
						drv_d  = 1'b1;
						sda_d  = shift_q[bitc_dec[2:0]];
					end else begin
						drv_d = 1'b0;
						sda_d = 1'b1;
					end
				end
				PH_DBIT_HIGH: begin
					scl_d = 1'b0;
					if (rmode_q) begin
						shift_d = {shift_q[6:0], req.sda_in};
					end
					if (bitc_q != 4'd0) begin
						bitc_d = bitc_dec;
						drv_d  = !rmode_q;
						sda_d  = rmode_q ? 1'b1 : shift_q[bitc_dec[2:0]];
					end else if (rmode_q) begin
						rv    = 1'b1;
						ri    = bytec_q[3:0];
						rb    = {shift_q[6:0], req.sda_in};
						drv_d = 1'b1;
						// NACK the final byte, ACK the rest
						sda_d = last_read;
					end else begin
						drv_d = 1'b0;
						sda_d = 1'b1;
					end
				end
				PH_AACK_HIGH: begin
					av      = 1'b1;
					ab      = req.sda_in;
					bytec_d = 5'd0;
					nb_take = 1'b1;
					nb_more = more_aack;
				end
				PH_DACK_HIGH: begin
					av      = !rmode_q;
					ab      = rmode_q ? 1'b0 : req.sda_in;
					bytec_d = bc_inc;
					nb_take = 1'b1;
					nb_more = more_dack;
				end
				PH_STOP_LOW: begin
					scl_d = 1'b1;
				end
				PH_STOP_HIGH: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					drv_d = 1'b0;
					dn    = 1'b1;
				end
				default: begin
					scl_d = scl_q;
				end
			endcase
			// After an acknowledge: start the next byte or pull SCL low ahead of the stop
			if (nb_take) begin
				scl_d = 1'b0;
				if (nb_more) begin
					bitc_d = 4'd7;
					if (rmode_q) begin
						shift_d = 8'd0;
						drv_d   = 1'b0;
						sda_d   = 1'b1;
					end else begin
						shift_d = buf_byte;
						drv_d   = 1'b1;
						sda_d   = buf_byte[7];
					end
				end else begin
					sda_d = 1'b0;
					drv_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp.scl_level   = scl_d;
		rsp.sda_level   = sda_d;
		rsp.sda_driving = drv_d;
		rsp.busy_res    = (phase_d != PH_IDLE);
		rsp.read_valid  = rv;
		rsp.read_index  = ri;
		rsp.read_byte   = rb;
		rsp.ack_valid   = av;
		rsp.ack_bit     = ab;
		rsp.done_res    = dn;
		rsp.rejected    = rj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bitc_q  <= 4'd0;
			bytec_q <= 5'd0;
			shift_q <= 8'd0;
			tgt_q   <= 7'd0;
			rmode_q <= 1'b0;
			len_q   <= 5'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			bitc_q  <= bitc_d;
			bytec_q <= bytec_d;
			shift_q <= shift_d;
			tgt_q   <= tgt_d;
			rmode_q <= rmode_d;
			len_q   <= len_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			drv_q   <= drv_d;
		end
	end

	// Hold the byte of a load that hit the address being prefetched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ram_wr_data;
	end

	a_begin_starts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.command == CMD_BEGIN) && (phase_q == PH_IDLE)
		|=> (phase_q == PH_START_HOLD) && scl_q && sda_q && drv_q)
		else $error("begin while idle did not enter the start hold");

	a_stop_releases: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.command == CMD_TICK) && (phase_q == PH_STOP_HIGH)
		|=> (phase_q == PH_IDLE) && scl_q && sda_q && !drv_q)
		else $error("bus not released after the stop");

	a_bytes_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (bytec_q <= len_q) && (bitc_q <= 4'd7))
		else $error("byte or bit counter out of range during a transaction");

	a_bypass_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		byp_hit_q |-> (buf_byte == $past(ram_wr_data)))
		else $error("prefetched buffer byte misses the last load");

	a_rejected_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.rejected |=> $stable(phase_q) || (phase_q != PH_IDLE))
		else $error("rejected begin disturbed the transaction");

endmodule

`default_nettype wire

/* dv/i2c_master_transaction_engine_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the I2C master transaction engine: bursty request driver,
// stalling response monitor and a cycle-level bus sequencer predictor.
// Depends on i2cm_pkg and i2c_master_transaction_engine_top.

module i2c_master_transaction_engine_top_test;
	import i2cm_pkg::*;

	localparam int BUF_SLOTS = 16;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	i2c_master_transaction_engine_top #(.BUF_DEPTH(BUF_SLOTS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// predicted sequencer state
	phase_t     bus_phase;
	logic [3:0] bit_cnt;
	logic [4:0] byte_cnt;
	logic [4:0] xfer_len;
	logic [7:0] shreg;
	logic [6:0] tgt_addr;
	logic       rd_mode;
	logic [7:0] wbuf [BUF_SLOTS];
	logic       scl_q;
	logic       sda_q;
	logic       sda_oe;

	req_t pending_q[$];
	rsp_t bus_beat_q[$];
	int   mismatches;
	int   burst_left;
	int   gap_left;
	int   stall_mode;
	int   rx_cycle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// SCL low, SDA set up with the current bit or released when receiving
	task automatic drive_bit_low(input logic sending);
		scl_q = 1'b0;
		if (sending) begin
			sda_oe = 1'b1;
			sda_q = shreg[bit_cnt[2:0]];
		end else begin
			sda_oe = 1'b0;
			sda_q = 1'b1;
		end
	endtask

	task automatic next_byte_or_stop();
		if (byte_cnt < xfer_len) begin
			bit_cnt = 4'd7;
			if (rd_mode) begin
				shreg = 8'h00;
				drive_bit_low(1'b0);
			end else begin
				shreg = wbuf[byte_cnt[3:0]];
				drive_bit_low(1'b1);
			end
			bus_phase = PH_DBIT_LOW;
		end else begin
			scl_q = 1'b0;
			sda_q = 1'b0;
			sda_oe = 1'b1;
			bus_phase = PH_STOP_LOW;
		end
	endtask

	task automatic advance_bus(input req_t r, output rsp_t o);
		o = '0;
		case (r.command)
			CMD_LOAD: begin
				if (r.buffer_index < BUF_SLOTS)
					wbuf[r.buffer_index] = r.write_byte;
			end
			CMD_BEGIN: begin
				if (bus_phase != PH_IDLE) begin
					o.rejected = 1'b1;
				end else begin
					tgt_addr = r.device_address;
					rd_mode = r.read_not_write;
					xfer_len = (r.byte_count > BUF_SLOTS) ? 5'(BUF_SLOTS) : r.byte_count;
					bit_cnt = '0;
					byte_cnt = '0;
					shreg = '0;
					scl_q = 1'b1;
					sda_q = 1'b1;
					sda_oe = 1'b1;
					bus_phase = PH_START_HOLD;
				end
			end
			CMD_TICK: begin
				case (bus_phase)
					PH_START_HOLD: begin
						sda_q = 1'b0;
						bus_phase = PH_START_LOW;
					end
					PH_START_LOW: begin
						shreg = {tgt_addr, rd_mode};
						bit_cnt = 4'd7;
						drive_bit_low(1'b1);
						bus_phase = PH_ABIT_LOW;
					end
					PH_ABIT_LOW: begin
						scl_q = 1'b1;
						bus_phase = PH_ABIT_HIGH;
					end
					PH_AACK_LOW: begin
						scl_q = 1'b1;
						bus_phase = PH_AACK_HIGH;
					end
					PH_DBIT_LOW: begin
						scl_q = 1'b1;
						bus_phase = PH_DBIT_HIGH;
					end
					PH_DACK_LOW: begin
						scl_q = 1'b1;
						bus_phase = PH_DACK_HIGH;
					end
					PH_ABIT_HIGH: begin
						if (bit_cnt > 0) begin
							bit_cnt = bit_cnt - 4'd1;
							drive_bit_low(1'b1);
							bus_phase = PH_ABIT_LOW;
						end else begin
							scl_q = 1'b0;
							sda_oe = 1'b0;
							sda_q = 1'b1;
							bus_phase = PH_AACK_LOW;
						end
					end
					PH_DBIT_HIGH: begin
						if (rd_mode)
							shreg = {shreg[6:0], r.sda_in};
						if (bit_cnt > 0) begin
							bit_cnt = bit_cnt - 4'd1;
							drive_bit_low(!rd_mode);
							bus_phase = PH_DBIT_LOW;
						end else begin
							scl_q = 1'b0;
							if (rd_mode) begin
								o.read_valid = 1'b1;
								o.read_index = byte_cnt[3:0];
								o.read_byte = shreg;
								// NACK the last byte of a read
								sda_oe = 1'b1;
								sda_q = ({1'b0, byte_cnt} + 6'd1 >= {1'b0, xfer_len});
							end else begin
								sda_oe = 1'b0;
								sda_q = 1'b1;
							end
							bus_phase = PH_DACK_LOW;
						end
					end
					PH_AACK_HIGH: begin
						o.ack_valid = 1'b1;
						o.ack_bit = r.sda_in;
						byte_cnt = '0;
						next_byte_or_stop();
					end
					PH_DACK_HIGH: begin
						if (!rd_mode) begin
							o.ack_valid = 1'b1;
							o.ack_bit = r.sda_in;
						end
						byte_cnt = byte_cnt + 5'd1;
						next_byte_or_stop();
					end
					PH_STOP_LOW: begin
						scl_q = 1'b1;
						bus_phase = PH_STOP_HIGH;
					end
					PH_STOP_HIGH: begin
						sda_q = 1'b1;
						sda_oe = 1'b0;
						scl_q = 1'b1;
						o.done_res = 1'b1;
						bus_phase = PH_IDLE;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		o.scl_level = scl_q;
		o.sda_level = sda_q;
		o.sda_driving = sda_oe;
		o.busy_res = (bus_phase != PH_IDLE);
	endtask

	function automatic req_t fresh_req(input logic [1:0] cmd);
		req_t r;
		r.command = cmd;
		r.sda_in = 1'($urandom_range(0, 1));
		r.read_not_write = 1'($urandom_range(0, 1));
		r.device_address = 7'($urandom_range(0, 127));
		r.byte_count = 5'($urandom_range(0, 16));
		r.buffer_index = 4'($urandom_range(0, 15));
		r.write_byte = 8'($urandom_range(0, 255));
		return r;
	endfunction

	task automatic push_load(input int slot, input int value);
		req_t r;
		r = fresh_req(CMD_LOAD);
		r.buffer_index = 4'(slot);
		r.write_byte = 8'(value);
		pending_q.push_back(r);
	endtask

	task automatic push_begin(input logic rnw, input int addr, input int len);
		req_t r;
		r = fresh_req(CMD_BEGIN);
		r.read_not_write = rnw;
		r.device_address = 7'(addr);
		r.byte_count = 5'(len);
		pending_q.push_back(r);
	endtask

	// sda_mode: 0 line low, 1 line high, otherwise random; noise_pct mixes in
	// loads and begins that arrive while the transfer is running
	task automatic push_ticks(input int n, input int sda_mode, input int noise_pct);
		req_t r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				if ($urandom_range(0, 1))
					pending_q.push_back(fresh_req(CMD_LOAD));
				else
					pending_q.push_back(fresh_req(CMD_BEGIN));
			end
			r = fresh_req(CMD_TICK);
			if (sda_mode == 0)
				r.sda_in = 1'b0;
			else if (sda_mode == 1)
				r.sda_in = 1'b1;
			pending_q.push_back(r);
		end
	endtask

	task automatic report(input string what, input int want, input int got);
		if (mismatches < 10)
			$display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
		mismatches++;
	endtask

	initial begin
		int len;
		int sel;
		logic rnw;

		mismatches = 0;
		bus_phase = PH_IDLE;
		bit_cnt = '0;
		byte_cnt = '0;
		xfer_len = '0;
		shreg = '0;
		tgt_addr = '0;
		rd_mode = 1'b0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		sda_oe = 1'b0;
		arst_n = 1'b0;

		// fill every slot before any write transfer can read one
		for (int s = 0; s < BUF_SLOTS; s++) begin
			case (s)
				0: push_load(s, 8'h00);
				1: push_load(s, 8'hFF);
				2: push_load(s, 8'h80);
				3: push_load(s, 8'h01);
				default: push_load(s, $urandom_range(0, 255));
			endcase
		end
		// zero length write to the top address: stop right after the address ACK
		push_begin(1'b0, 127, 0);
		push_ticks(22, 0, 0);
		// single byte read from address zero, line held high
		push_begin(1'b1, 0, 1);
		push_ticks(22 + 18, 1, 0);
		// NACKed write that must run on, with a reload and a rejected begin mid-flight
		push_begin(1'b0, 'h55, 2);
		push_ticks(5, 1, 0);
		push_load(1, 8'h3C);
		push_begin(1'b1, 'h2A, 3);
		push_ticks(22 + 36 - 5, 1, 0);
		// longest read
		push_begin(1'b1, 'h6B, 16);
		push_ticks(22 + 18 * 16, 2, 0);

		while (pending_q.size() < 900) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				sel = $urandom_range(0, 99);
				if (sel < 70)
					len = $urandom_range(0, 3);
				else if (sel < 96)
					len = $urandom_range(4, 8);
				else
					len = 16;
				rnw = 1'($urandom_range(0, 1));
				push_begin(rnw, $urandom_range(0, 127), len);
				// cut some transfers short so the next begin lands on a busy engine
				if ($urandom_range(0, 9) == 0)
					push_ticks(22 + 18 * len - $urandom_range(1, 12), 2, 6);
				else
					push_ticks(22 + 18 * len, 2, 6);
			end else if (sel < 92) begin
				repeat ($urandom_range(1, 3))
					pending_q.push_back(fresh_req(CMD_LOAD));
			end else begin
				len = $urandom_range(1, 3);
				push_ticks(len, 2, 0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || req_valid)
			@(posedge clk);
		while (bus_beat_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && bus_beat_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// request driver: bursts of beats with random gaps, prediction on each accepted beat
	always @(posedge clk or negedge arst_n) begin : drive_req
		rsp_t predicted;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (req_valid && req_ready) begin
				advance_bus(req_data, predicted);
				bus_beat_q.push_back(predicted);
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					req_data <= pending_q.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 40);
						gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response stall pattern: the style is picked at random and changes over the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_mode <= 0;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 300 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(0, 1));
				2: rsp_ready <= (rx_cycle % 3 != 0);
				default: rsp_ready <= (rx_cycle[4:3] == 2'b00);
			endcase
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (bus_beat_q.size() == 0) begin
				report("unexpected beat", 0, rsp_data);
			end else begin
				want = bus_beat_q.pop_front();
				if (rsp_data.scl_level !== want.scl_level)
					report("scl_level", want.scl_level, rsp_data.scl_level);
				if (rsp_data.sda_level !== want.sda_level)
					report("sda_level", want.sda_level, rsp_data.sda_level);
				if (rsp_data.sda_driving !== want.sda_driving)
					report("sda_driving", want.sda_driving, rsp_data.sda_driving);
				if (rsp_data.busy_res !== want.busy_res)
					report("busy_res", want.busy_res, rsp_data.busy_res);
				if (rsp_data.read_valid !== want.read_valid)
					report("read_valid", want.read_valid, rsp_data.read_valid);
				if (rsp_data.read_index !== want.read_index)
					report("read_index", want.read_index, rsp_data.read_index);
				if (rsp_data.read_byte !== want.read_byte)
					report("read_byte", want.read_byte, rsp_data.read_byte);
				if (rsp_data.ack_valid !== want.ack_valid)
					report("ack_valid", want.ack_valid, rsp_data.ack_valid);
				if (rsp_data.ack_bit !== want.ack_bit)
					report("ack_bit", want.ack_bit, rsp_data.ack_bit);
				if (rsp_data.done_res !== want.done_res)
					report("done_res", want.done_res, rsp_data.done_res);
				if (rsp_data.rejected !== want.rejected)
					report("rejected", want.rejected, rsp_data.rejected);
			end
		end
	end

endmodule

/* files.f */
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_ram.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2c_master_transaction_engine_top.sv
dv/i2c_master_transaction_engine_top_test.sv
